@@ hdl/mts_pkg.sv @@
package mts_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  // Result word layout, lowest bits first.
  localparam int OUT_USED_W  = STATUS_W + 2 * VALUE_W + COUNT_OUT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic pop_load;
    logic out_load;
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/mts_ram.sv @@
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mts_ctrl.sv @@
module mts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mts_pkg::stat_t stat,
  output mts_pkg::ctrl_t ctrl
);
  import mts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = stat.pop_ok ? ST_POP : ST_PUT;
        end
      end
      ST_POP: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    ctrl.accept   = 1'b0;
    ctrl.pop_load = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        ctrl.accept = s_tvalid;
      end
      ST_POP: begin
        ctrl.pop_load = 1'b1;
      end
      ST_PUT: begin
        ctrl.out_load = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/mts_datapath.sv @@
module mts_datapath #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd,
  input  logic [mts_pkg::VALUE_W-1:0]     value,
  input  mts_pkg::ctrl_t                  ctrl,
  output mts_pkg::stat_t                  stat,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mts_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mts_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             mcount;
  logic signed [VALUE_W-1:0] top_reg;
  logic signed [VALUE_W-1:0] min_reg;
  logic [STATUS_W-1:0]       status;
  logic                      min_popped;

  logic                      full;
  logic                      empty;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      min_push;
  logic                      min_pop;
  logic [CW-1:0]             v_rd;
  logic [CW-1:0]             m_rd;
  logic [VALUE_W-1:0]        v_rdata;
  logic [VALUE_W-1:0]        m_rdata;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign full    = (count == CW'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = (cmd == CMD_PUSH) && !full;
  assign pop_ok  = (cmd == CMD_POP) && !empty;

  // A value equal to the current minimum goes onto the minima stack again.
  assign min_push = (mcount == '0) || ($signed(value) <= min_reg);
  assign min_pop  = (mcount != '0) && (top_reg == min_reg);

  // The entries just below the tops become the new tops after a pop.
  assign v_rd = count - CW'(2);
  assign m_rd = mcount - CW'(2);

  assign stat.pop_ok   = pop_ok;
  assign stat.out_free = !m_tvalid || m_tready;

  mts_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (ctrl.accept && push_ok),
    .waddr (count[AW-1:0]),
    .wdata (value),
    .raddr (v_rd[AW-1:0]),
    .rdata (v_rdata)
  );

  mts_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (ctrl.accept && push_ok && min_push),
    .waddr (mcount[AW-1:0]),
    .wdata (value),
    .raddr (m_rd[AW-1:0]),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      mcount <= '0;
    end else if (ctrl.accept) begin
      if (push_ok) begin
        count <= count + CW'(1);
        if (min_push) begin
          mcount <= mcount + CW'(1);
        end
      end else if (pop_ok) begin
        count <= count - CW'(1);
        if (min_pop) begin
          mcount <= mcount - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      min_popped <= min_pop;
      if (push_ok) begin
        status  <= STATUS_OK;
        top_reg <= $signed(value);
        if (min_push) begin
          min_reg <= $signed(value);
        end
      end else if (pop_ok) begin
        status <= STATUS_OK;
      end else if (cmd == CMD_PUSH) begin
        status <= STATUS_PUSH_FULL;
      end else begin
        status <= STATUS_POP_EMPTY;
      end
    end else if (ctrl.pop_load) begin
      top_reg <= $signed(v_rdata);
      if (min_popped) begin
        min_reg <= $signed(m_rdata);
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}},
                  empty,
                  count_ext[COUNT_OUT_W-1:0],
                  (!empty && mcount != '0) ? min_reg : '0,
                  empty ? '0 : top_reg,
                  status};
    end
  end

endmodule

@@ hdl/min_tracking_stack.sv @@
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: cmd; tdata: value
// m_*      out  tdata: status, top_value, min_value, count, is_empty
//
// The result register loads in state ST_PUT, which follows acceptance directly for a
// push and follows ST_POP for a pop: ST_POP waits on the registered read port of the
// two stack memories, which supplies the new top entries. ST_PUT holds until the
// output register is free, and one item is in work at a time.
// The next item is accepted while the previous result still waits for m_tready,
// but its own result is held until the output register frees up.
// Synchronous reset empties both stacks; the memories need no clearing pass.
module min_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,   // cmd
  input  logic [mts_pkg::VALUE_W-1:0]     s_tdata,   // value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[1:0], top_value[33:2], min_value[65:34], count[72:66], is_empty[73]
  output logic [mts_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mts_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (s_tuser),
    .value    (s_tdata),
    .ctrl     (ctrl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ hdl/mts_checker.sv @@
module mts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic [mts_pkg::VALUE_W-1:0]     s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mts_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mts_pkg::*;

  logic [STATUS_W-1:0]    o_status;
  logic signed [31:0]     o_top;
  logic signed [31:0]     o_min;
  logic [COUNT_OUT_W-1:0] o_count;
  logic                   o_empty;

  assign o_status = m_tdata[1:0];
  assign o_top    = m_tdata[33:2];
  assign o_min    = m_tdata[65:34];
  assign o_count  = m_tdata[72:66];
  assign o_empty  = m_tdata[73];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_empty == (o_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_empty |-> (o_top == 0) && (o_min == 0))
    else $error("empty stack reports nonzero top or minimum");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (o_status == STATUS_POP_EMPTY) |-> o_empty)
    else $error("rejected pop on a nonempty stack");

  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_empty |-> (o_min <= o_top))
    else $error("minimum exceeds top value");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
